FILE: design/cpu6502_pkg.sv
// ----------------------------------------------------------------------------
// cpu6502_pkg
// Operation codes, status bit positions and the execute result record
// shared by the execute unit and the top level.
// ----------------------------------------------------------------------------
package cpu6502_pkg;

  typedef enum logic [3:0] {
    OP_ADC  = 4'd0,
    OP_SBC  = 4'd1,
    OP_AND  = 4'd2,
    OP_CLC  = 4'd3,
    OP_CLD  = 4'd4,
    OP_BPL  = 4'd5,
    OP_BMI  = 4'd6,
    OP_BVC  = 4'd7,
    OP_BVS  = 4'd8,
    OP_BCC  = 4'd9,
    OP_BCS  = 4'd10,
    OP_BNE  = 4'd11,
    OP_BEQ  = 4'd12,
    OP_LOAD = 4'd13
  } op_t;

  localparam int unsigned FLAG_C_BIT = 0;
  localparam int unsigned FLAG_Z_BIT = 1;
  localparam int unsigned FLAG_D_BIT = 3;
  localparam int unsigned FLAG_V_BIT = 6;
  localparam int unsigned FLAG_N_BIT = 7;

  localparam logic [7:0] STATUS_RESET = 8'h20;

  localparam logic [1:0] EXTRA_NONE  = 2'd0;
  localparam logic [1:0] EXTRA_TAKEN = 2'd1;
  localparam logic [1:0] EXTRA_PAGE  = 2'd2;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  status;
    logic [15:0] next_pc;
    logic [1:0]  extra_cycles;
    logic        may_add_cycle;
  } exec_result_t;

endpackage

FILE: design/cpu6502_alu_and_branch_unit_core.sv
// ----------------------------------------------------------------------------
// cpu6502_alu_and_branch_unit_core
// 6502 accumulator, status byte, binary ALU and conditional branch unit.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// in       in_valid / in_stall   op, operand, pc
// out      out_valid / out_stall acc_out, status_out, next_pc, extra_cycles,
//                                may_add_cycle
//
// A request is registered in the input register, executed against the
// accumulator and status, and held in the result register. One request per
// cycle is sustained while the result side does not stall.
// Reset clears the accumulator, loads status with 0x20 and empties both
// registers. A stall on the result side backs up through the input register.
// ----------------------------------------------------------------------------
module cpu6502_alu_and_branch_unit_core
  import cpu6502_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  op,
  input  logic [7:0]  operand,
  input  logic [15:0] pc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  acc_out,
  output logic [7:0]  status_out,
  output logic [15:0] next_pc,
  output logic [1:0]  extra_cycles,
  output logic        may_add_cycle
);

  logic         req_valid;
  logic [3:0]   req_op;
  logic [7:0]   req_operand;
  logic [15:0]  req_pc;
  logic [7:0]   acc;
  logic [7:0]   status;
  logic         advance;
  exec_result_t exec_res;
  exec_result_t res;

  cpu6502_exec u_exec (
    .op      (req_op),
    .operand (req_operand),
    .pc      (req_pc),
    .acc     (acc),
    .status  (status),
    .result  (exec_res)
  );

  assign advance  = req_valid && !(out_valid && out_stall);
  assign in_stall = req_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      req_op      <= op;
      req_operand <= operand;
      req_pc      <= pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 8'd0;
      status    <= STATUS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        acc       <= exec_res.acc;
        status    <= exec_res.status;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      res <= exec_res;
    end
  end

  assign acc_out       = res.acc;
  assign status_out    = res.status;
  assign next_pc       = res.next_pc;
  assign extra_cycles  = res.extra_cycles;
  assign may_add_cycle = res.may_add_cycle;

endmodule

FILE: design/cpu6502_exec.sv
// ----------------------------------------------------------------------------
// cpu6502_exec
// Combinational execute step: binary add and subtract with carry, AND,
// flag clears, accumulator load and the eight conditional branches.
// ----------------------------------------------------------------------------
module cpu6502_exec
  import cpu6502_pkg::*;
(
  input  logic [3:0]   op,
  input  logic [7:0]   operand,
  input  logic [15:0]  pc,
  input  logic [7:0]   acc,
  input  logic [7:0]   status,
  output exec_result_t result
);

  logic [7:0]  addend;
  logic [8:0]  sum;
  logic        ovf;
  logic        take;
  logic        is_branch;
  logic [15:0] target;
  logic [7:0]  logic_val;

  assign addend = (op == OP_SBC) ? ~operand : operand;
  assign sum    = {1'b0, acc} + {1'b0, addend} + {8'd0, status[FLAG_C_BIT]};
  assign ovf    = ~(acc[7] ^ addend[7]) & (acc[7] ^ sum[7]);
  assign target = pc + {{8{operand[7]}}, operand};
  assign logic_val = (op == OP_AND) ? (acc & operand) : operand;
  assign is_branch = op inside {[OP_BPL:OP_BEQ]};

  always_comb begin
    case (op)
      OP_BPL:  take = ~status[FLAG_N_BIT];
      OP_BMI:  take =  status[FLAG_N_BIT];
      OP_BVC:  take = ~status[FLAG_V_BIT];
      OP_BVS:  take =  status[FLAG_V_BIT];
      OP_BCC:  take = ~status[FLAG_C_BIT];
      OP_BCS:  take =  status[FLAG_C_BIT];
      OP_BNE:  take = ~status[FLAG_Z_BIT];
      OP_BEQ:  take =  status[FLAG_Z_BIT];
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    result.acc           = acc;
    result.status        = status;
    result.next_pc       = pc;
    result.extra_cycles  = EXTRA_NONE;
    result.may_add_cycle = 1'b0;
    case (op)
      OP_ADC, OP_SBC: begin
        result.acc                = sum[7:0];
        result.status[FLAG_C_BIT] = sum[8];
        result.status[FLAG_V_BIT] = ovf;
        result.status[FLAG_Z_BIT] = (sum[7:0] == 8'd0);
        result.status[FLAG_N_BIT] = sum[7];
        result.may_add_cycle      = 1'b1;
      end
      OP_AND, OP_LOAD: begin
        result.acc                = logic_val;
        result.status[FLAG_Z_BIT] = (logic_val == 8'd0);
        result.status[FLAG_N_BIT] = logic_val[7];
        result.may_add_cycle      = (op == OP_AND);
      end
      OP_CLC: result.status[FLAG_C_BIT] = 1'b0;
      OP_CLD: result.status[FLAG_D_BIT] = 1'b0;
      default: begin
        if (is_branch && take) begin
          result.next_pc      = target;
          result.extra_cycles = (target[15:8] != pc[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
        end
      end
    endcase
  end

endmodule

FILE: tb/cpu6502_alu_and_branch_unit_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu6502_alu_and_branch_unit_core_tb
// Self-checking bench for the 6502 ALU and branch unit. Directed requests hit
// the flag edges of ADC, SBC, AND and loads, the clear operations, every
// branch taken (BMI, BVC, BCS and BNE also not taken) with page crosses and
// address wrap, and the two unused codes. Random requests follow, with random
// gaps on the request side and random stalls on the result side. An in-bench
// model of the accumulator and status byte predicts each result, and the
// results are checked in order.
module cpu6502_alu_and_branch_unit_core_tb
  import cpu6502_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_COUNT   = 950;
  localparam int unsigned CHUNK          = 50;
  localparam logic [3:0]  OP_UNUSED_14   = 4'd14;
  localparam logic [3:0]  OP_UNUSED_15   = 4'd15;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  op;
  logic [7:0]  operand;
  logic [15:0] pc;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  acc_out;
  logic [7:0]  status_out;
  logic [15:0] next_pc;
  logic [1:0]  extra_cycles;
  logic        may_add_cycle;

  logic [7:0]   acc_model;
  logic [7:0]   status_model;
  exec_result_t predicted_exec[$];
  int unsigned  mismatches;
  bit           gaps_on;

  cpu6502_alu_and_branch_unit_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .operand      (operand),
    .pc           (pc),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .acc_out      (acc_out),
    .status_out   (status_out),
    .next_pc      (next_pc),
    .extra_cycles (extra_cycles),
    .may_add_cycle(may_add_cycle)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic exec_result_t execute_op(input logic [3:0] code, input logic [7:0] data,
                                              input logic [15:0] addr);
    exec_result_t res;
    logic [7:0]   m;
    logic [8:0]   sum;
    logic [15:0]  target;
    logic         take;
    logic         sets_zn;
    res = '0;
    res.next_pc = addr;
    res.extra_cycles = EXTRA_NONE;
    take = 1'b0;
    sets_zn = 1'b0;
    m = data;
    case (code)
      OP_ADC, OP_SBC: begin
        if (code == OP_SBC) m = ~data;
        sum = {1'b0, acc_model} + {1'b0, m} + {8'd0, status_model[FLAG_C_BIT]};
        status_model[FLAG_C_BIT] = sum[8];
        status_model[FLAG_V_BIT] = ~(acc_model[7] ^ m[7]) & (acc_model[7] ^ sum[7]);
        acc_model = sum[7:0];
        sets_zn = 1'b1;
        res.may_add_cycle = 1'b1;
      end
      OP_AND: begin
        acc_model = acc_model & data;
        sets_zn = 1'b1;
        res.may_add_cycle = 1'b1;
      end
      OP_CLC:  status_model[FLAG_C_BIT] = 1'b0;
      OP_CLD:  status_model[FLAG_D_BIT] = 1'b0;
      OP_BPL:  take = !status_model[FLAG_N_BIT];
      OP_BMI:  take = status_model[FLAG_N_BIT];
      OP_BVC:  take = !status_model[FLAG_V_BIT];
      OP_BVS:  take = status_model[FLAG_V_BIT];
      OP_BCC:  take = !status_model[FLAG_C_BIT];
      OP_BCS:  take = status_model[FLAG_C_BIT];
      OP_BNE:  take = !status_model[FLAG_Z_BIT];
      OP_BEQ:  take = status_model[FLAG_Z_BIT];
      OP_LOAD: begin
        acc_model = data;
        sets_zn = 1'b1;
      end
      default: ;
    endcase
    if (sets_zn) begin
      status_model[FLAG_Z_BIT] = (acc_model == 8'h00);
      status_model[FLAG_N_BIT] = acc_model[7];
    end
    if (take) begin
      target = addr + {{8{data[7]}}, data};
      res.next_pc = target;
      res.extra_cycles = (target[15:8] != addr[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
    end
    res.acc = acc_model;
    res.status = status_model;
    return res;
  endfunction

  task automatic send_request(input logic [3:0] code, input logic [7:0] data,
                              input logic [15:0] addr);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    operand  <= data;
    pc       <= addr;
    do @(posedge clk); while (in_stall);
    predicted_exec.push_back(execute_op(code, data, addr));
  endtask

  task automatic test_logic_and_load();
    send_request(OP_LOAD, 8'hFF, 16'h0000);
    send_request(OP_AND,  8'h8F, 16'hFFFF);
    send_request(OP_AND,  8'h70, 16'h8000);
  endtask

  task automatic test_add_subtract();
    send_request(OP_LOAD, 8'h7F, 16'h0001);
    send_request(OP_ADC,  8'h01, 16'h0002);
    send_request(OP_ADC,  8'hFF, 16'h0003);
    send_request(OP_ADC,  8'h00, 16'h0004);
    send_request(OP_CLC,  8'hA5, 16'h0005);
    send_request(OP_SBC,  8'h00, 16'h0006);
    send_request(OP_SBC,  8'h7F, 16'h0007);
    send_request(OP_CLD,  8'h5A, 16'h0008);
  endtask

  task automatic test_branches();
    // C and Z set, V and N clear
    send_request(OP_BEQ,  8'hFE, 16'h0100);
    send_request(OP_BCS,  8'h02, 16'h4000);
    send_request(OP_BVC,  8'h80, 16'h0010);
    send_request(OP_BPL,  8'h7F, 16'hFFF0);
    send_request(OP_BNE,  8'h10, 16'h1234);
    send_request(OP_BMI,  8'hF0, 16'h5678);
    // move to V and N set, C and Z clear
    send_request(OP_LOAD, 8'h40, 16'h0009);
    send_request(OP_ADC,  8'h3F, 16'h000A);
    send_request(OP_BMI,  8'h7F, 16'h12F0);
    send_request(OP_BVS,  8'h01, 16'h20FE);
    send_request(OP_BCC,  8'hFF, 16'h3000);
    send_request(OP_BNE,  8'h00, 16'hFFFF);
    send_request(OP_BVC,  8'h22, 16'h7777);
    send_request(OP_BCS,  8'h33, 16'h8888);
  endtask

  task automatic test_unused_codes();
    send_request(OP_UNUSED_14, 8'hFF, 16'hFFFF);
    send_request(OP_UNUSED_15, 8'h80, 16'h00FF);
  endtask

  task automatic test_random_traffic();
    logic [3:0] code;
    logic [7:0] data;
    for (int unsigned i = 0; i < RANDOM_COUNT; i++) begin
      if (i % CHUNK == 0) gaps_on = ((i / CHUNK) % 3) != 0;
      code = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       data = 8'h00;
          1:       data = 8'h7F;
          2:       data = 8'h80;
          default: data = 8'hFF;
        endcase
      end else begin
        data = 8'($urandom());
      end
      send_request(code, data, 16'($urandom()));
    end
    gaps_on = 1'b1;
  endtask

  initial begin : result_stall
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = gaps_on ? $urandom_range(0, 7) : 0;
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  always @(posedge clk) begin : check_results
    exec_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_exec.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: acc %h status %h next_pc %h extra %0d may_add %0b",
                   acc_out, status_out, next_pc, extra_cycles, may_add_cycle);
      end else begin
        want = predicted_exec.pop_front();
        if (acc_out !== want.acc || status_out !== want.status ||
            next_pc !== want.next_pc || extra_cycles !== want.extra_cycles ||
            may_add_cycle !== want.may_add_cycle) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("expected: acc %h status %h next_pc %h extra %0d may_add %0b",
                     want.acc, want.status, want.next_pc, want.extra_cycles,
                     want.may_add_cycle);
            $display("actual:   acc %h status %h next_pc %h extra %0d may_add %0b",
                     acc_out, status_out, next_pc, extra_cycles, may_add_cycle);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("cpu6502_alu_and_branch_unit_core: mismatch");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_ADC;
    operand      = 8'h00;
    pc           = 16'h0000;
    mismatches   = 0;
    gaps_on      = 1'b1;
    acc_model    = 8'h00;
    status_model = STATUS_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_logic_and_load();
    test_add_subtract();
    test_branches();
    test_unused_codes();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (predicted_exec.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("cpu6502_alu_and_branch_unit_core: match");
    end else begin
      $display("cpu6502_alu_and_branch_unit_core: mismatch");
    end
    $finish;
  end

endmodule
